FILE: hdl/mm_pkg.sv
`default_nettype none

package mm_pkg;

  localparam int DIM_IDX_W = 3;
  localparam int DIM_W = 4;
  localparam int VAL_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [1:0] op;
    logic [DIM_IDX_W-1:0] row;
    logic [DIM_IDX_W-1:0] col;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [DIM_IDX_W-1:0] out_row;
    logic [DIM_IDX_W-1:0] out_col;
    logic signed [VAL_W-1:0] product;
    logic last;
  } out_word_t;

  typedef struct packed {
    logic first;
    logic fin;
    logic [DIM_IDX_W-1:0] row;
    logic [DIM_IDX_W-1:0] col;
    logic last;
  } term_tag_t;

endpackage

`default_nettype wire

FILE: hdl/matrix_multiply.sv
`default_nettype none

// channel  ports                                   handshake
// in       start, busy, in_data                    taken when start && !busy
// out      out_valid, out_data                     one word per strobe cycle
// cfg      cfg_we, cfg_idx, cfg_wdata              taken when cfg_we
//
// A load word does not raise busy; loads may follow back to back.
// A compute word holds busy until the final result word is output: one
// multiply-accumulate per cycle, set by the single read port of each store.
// Reset clears control and restores the dimension registers to 8; the stores
// keep their contents. The receiver cannot stall; a result word comes after each
// run of inner_dim multiply-accumulates.

module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [DIM_W-1:0]     cfg_wdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(DEPTH);
  localparam int LIM = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int PW = 2 * VAL_W;
  localparam int ACC_W = PW + 4;

  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] nr, nk, nc;

  logic signed [VAL_W-1:0] mem_a [DEPTH];
  logic signed [VAL_W-1:0] mem_b [DEPTH];
  logic signed [VAL_W-1:0] rd_a_r, rd_b_r;

  logic                 busy_r, busy_nxt;
  logic                 run_r, run_nxt;
  logic [DIM_IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                 k_end, j_end, i_end;
  logic [AW-1:0]        rd_addr_a, rd_addr_b, wr_addr;
  logic                 accept, wr_ok;

  logic                   s1_vld_r, s2_vld_r, done_vld_r, out_valid_r;
  term_tag_t              issue_tag, s1_tag_r, s2_tag_r, done_tag_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0]       sat_val;
  out_word_t              out_data_r;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(LIM)) begin
      r = DIM_W'(LIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign nr = clamp_dim(rows_a_r);
  assign nk = clamp_dim(inner_dim_r);
  assign nc = clamp_dim(cols_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROWS_A: rows_a_r <= cfg_wdata;
        CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        CFG_COLS_B: cols_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = start && !busy_r;
  assign wr_ok = (int'(in_data.row) < MAX_DIM) && (int'(in_data.col) < MAX_DIM);
  assign wr_addr = AW'(AW'(in_data.row) * AW'(MAX_DIM) + AW'(in_data.col));
  assign rd_addr_a = AW'(AW'(i_r) * AW'(MAX_DIM) + AW'(k_r));
  assign rd_addr_b = AW'(AW'(k_r) * AW'(MAX_DIM) + AW'(j_r));

  always_ff @(posedge clk) begin
    if (accept && wr_ok && in_data.op == OP_LOAD_A) begin
      mem_a[wr_addr] <= in_data.value;
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (accept && wr_ok && in_data.op == OP_LOAD_B) begin
      mem_b[wr_addr] <= in_data.value;
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  assign k_end = {1'b0, k_r} == nk - DIM_W'(1);
  assign j_end = {1'b0, j_r} == nc - DIM_W'(1);
  assign i_end = {1'b0, i_r} == nr - DIM_W'(1);

  assign issue_tag = '{first: k_r == '0, fin: k_end, row: i_r, col: j_r,
                       last: k_end && j_end && i_end};

  always_comb begin
    run_nxt = run_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    busy_nxt = busy_r;
    if (accept && in_data.op == OP_COMPUTE) begin
      run_nxt = 1'b1;
      busy_nxt = 1'b1;
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end else if (run_r) begin
      if (k_end) begin
        k_nxt = '0;
        if (j_end) begin
          j_nxt = '0;
          if (i_end) begin
            run_nxt = 1'b0;
          end else begin
            i_nxt = i_r + DIM_IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + DIM_IDX_W'(1);
        end
      end else begin
        k_nxt = k_r + DIM_IDX_W'(1);
      end
    end
    if (done_vld_r && done_tag_r.last) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    if (s2_tag_r.first) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_comb begin
    if (&acc_r[ACC_W-1:VAL_W+15] || ~|acc_r[ACC_W-1:VAL_W+15]) begin
      sat_val = acc_r[VAL_W+15:16];
    end else if (acc_r[ACC_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      run_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      run_r <= run_nxt;
      s1_vld_r <= run_r;
      s2_vld_r <= s1_vld_r;
      done_vld_r <= s2_vld_r && s2_tag_r.fin;
      out_valid_r <= done_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    s1_tag_r <= issue_tag;
    s2_tag_r <= s1_tag_r;
    prod_r <= PW'(rd_a_r) * PW'(rd_b_r);
    if (s2_vld_r) begin
      acc_r <= acc_nxt;
      done_tag_r <= s2_tag_r;
    end
    out_data_r <= '{out_row: done_tag_r.row, out_col: done_tag_r.col,
                    product: sat_val, last: done_tag_r.last};
  end

  assign busy = busy_r;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef ASSERT_OFF
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_data.last)
    else $error("busy dropped without the final word");

  a_out_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word outside a compute");

  a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result word after the final word");

  a_compute_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.op == OP_COMPUTE |=> busy)
    else $error("compute accepted without busy");
`endif

endmodule

`default_nettype wire
